// File: rtl/pbb_pkg.sv
// Shared constants, register codes and pipeline tag type for the box projector.
package pbb_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_W      = 32;
   localparam int ACC_W       = 64;
   localparam int NUM_CORNERS = 8;
   localparam int CORNER_W    = $clog2(NUM_CORNERS);
   localparam int DIV_STEPS   = WORD_W;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_M00_M01 = 3'd0,
      CSR_M02_M03 = 3'd1,
      CSR_M10_M11 = 3'd2,
      CSR_M12_M13 = 3'd3,
      CSR_M20_M21 = 3'd4,
      CSR_M22_M23 = 3'd5
   } csr_idx_type;

   // Control bits that travel with one corner down the pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic degen;
   } tag_type;

endpackage

// File: rtl/pbb_div.sv
// Pipelined fixed-point divider: two numerators over one shared denominator.
module pbb_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pbb_pkg::ACC_W-1:0]      num_u,
   input  logic [pbb_pkg::ACC_W-1:0]      num_v,
   input  logic [pbb_pkg::ACC_W-1:0]      den,
   input  pbb_pkg::tag_type               tag_i,
   output logic signed [pbb_pkg::WORD_W-1:0] quo_u,
   output logic signed [pbb_pkg::WORD_W-1:0] quo_v,
   output logic [1:0]                     sat_o,
   output pbb_pkg::tag_type               tag_o
);
   localparam int AW = pbb_pkg::ACC_W;
   localparam int QW = pbb_pkg::WORD_W;
   localparam int NS = pbb_pkg::DIV_STEPS;
   localparam int F  = pbb_pkg::FRAC_BITS;

   logic [AW-1:0]    rem_ff [0:NS][2];
   logic [QW-1:0]    dlo_ff [0:NS][2];
   logic [QW-1:0]    q_ff   [0:NS][2];
   logic [1:0]       neg_ff [0:NS];
   logic [1:0]       ovf_ff [0:NS];
   logic [AW-1:0]    md_ff  [0:NS];
   pbb_pkg::tag_type tag_ff [0:NS];

   // Stage zero: magnitudes, sign, range check and initial partial remainder.
   logic [AW-1:0]   num_s [2];
   logic [AW-1:0]   mn    [2];
   logic [AW+F-1:0] dext  [2];
   logic [AW-1:0]   md;
   logic [AW-1:0]   rem0_in [2];
   logic [QW-1:0]   dlo0_in [2];
   logic [1:0]      neg0_in;
   logic [1:0]      ovf0_in;

   always_comb begin
      num_s[0] = num_u;
      num_s[1] = num_v;
      md = den[AW-1] ? (AW'(0) - den) : den;
      for (int l = 0; l < 2; l++) begin
         mn[l]      = num_s[l][AW-1] ? (AW'(0) - num_s[l]) : num_s[l];
         neg0_in[l] = num_s[l][AW-1] ^ den[AW-1];
         rem0_in[l] = mn[l] >> (QW - F);
         ovf0_in[l] = rem0_in[l] >= md;
         dext[l]    = {mn[l], F'(0)};
         dlo0_in[l] = dext[l][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l] <= rem0_in[l];
         dlo_ff[0][l] <= dlo0_in[l];
         q_ff[0][l]   <= '0;
      end
      neg_ff[0] <= neg0_in;
      ovf_ff[0] <= ovf0_in;
      md_ff[0]  <= md;
      if (reset) begin
         tag_ff[0] <= '0;
      end else begin
         tag_ff[0] <= tag_i;
      end
   end

   // One quotient bit per stage, restoring.
   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [AW:0]   remx [2];
      logic [AW+1:0] diff [2];
      logic [AW-1:0] rem_in [2];
      logic [1:0]    ge;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            remx[l]   = {rem_ff[k-1][l], dlo_ff[k-1][l][QW-1]};
            diff[l]   = {1'b0, remx[l]} - {2'b00, md_ff[k-1]};
            ge[l]     = !diff[l][AW+1];
            rem_in[l] = ge[l] ? diff[l][AW-1:0] : remx[l][AW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[k][l] <= rem_in[l];
            dlo_ff[k][l] <= {dlo_ff[k-1][l][QW-2:0], 1'b0};
            q_ff[k][l]   <= {q_ff[k-1][l][QW-2:0], ge[l]};
         end
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         md_ff[k]  <= md_ff[k-1];
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // Apply sign and clamp to the word range.
   localparam logic [QW-1:0] MAX_POS = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] MIN_NEG = {1'b1, {(QW-1){1'b0}}};

   logic [QW-1:0] res_in [2];
   logic [1:0]    sat_in;
   logic [QW-1:0] res_ff [2];
   logic [1:0]    sat_ff;
   pbb_pkg::tag_type tago_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (ovf_ff[NS][l]) begin
            sat_in[l] = 1'b1;
            res_in[l] = neg_ff[NS][l] ? MIN_NEG : MAX_POS;
         end else if (neg_ff[NS][l]) begin
            sat_in[l] = q_ff[NS][l] > MIN_NEG;
            res_in[l] = sat_in[l] ? MIN_NEG : (QW'(0) - q_ff[NS][l]);
         end else begin
            sat_in[l] = q_ff[NS][l] > MAX_POS;
            res_in[l] = sat_in[l] ? MAX_POS : q_ff[NS][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
      sat_ff    <= sat_in;
      if (reset) begin
         tago_ff <= '0;
      end else begin
         tago_ff <= tag_ff[NS];
      end
   end

   assign quo_u = $signed(res_ff[0]);
   assign quo_v = $signed(res_ff[1]);
   assign sat_o = sat_ff;
   assign tag_o = tago_ff;

endmodule

// File: rtl/projected_box_bounds.sv
// Top level: projects the eight corners of a 3-D box and bounds their image points.
//
// Projects an axis-aligned box through a 3x4 camera matrix and returns the
// 2-D bounds of the eight image points in signed fixed point. Raise start
// with the six box fields while busy is low; the block takes one corner per
// cycle through a shared multiply, sum and divide pipeline, so a new box is
// taken in the cycle the last corner of the previous one issues. The answer
// appears on the rsp_ ports for exactly one cycle with rsp_valid high; the
// receiver cannot stall it, so capture it then. Write the matrix through the
// csr_ port (always ready) only while no box is in flight. Corners with w
// equal to zero are dropped and set degenerate; if all are dropped the bounds
// read zero. Quotients beyond the 32-bit range are clamped and set saturated.
module projected_box_bounds (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [pbb_pkg::WORD_W-1:0]    req_box_min_x,
   input  logic signed [pbb_pkg::WORD_W-1:0]    req_box_max_x,
   input  logic signed [pbb_pkg::WORD_W-1:0]    req_box_min_y,
   input  logic signed [pbb_pkg::WORD_W-1:0]    req_box_max_y,
   input  logic signed [pbb_pkg::WORD_W-1:0]    req_box_min_z,
   input  logic signed [pbb_pkg::WORD_W-1:0]    req_box_max_z,
   output logic                                 rsp_valid,
   output logic signed [pbb_pkg::WORD_W-1:0]    rsp_image_min_u,
   output logic signed [pbb_pkg::WORD_W-1:0]    rsp_image_max_u,
   output logic signed [pbb_pkg::WORD_W-1:0]    rsp_image_min_v,
   output logic signed [pbb_pkg::WORD_W-1:0]    rsp_image_max_v,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pbb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pbb_pkg::ACC_W-1:0]            csr_wdata
);
   localparam int WW = pbb_pkg::WORD_W;
   localparam int AW = pbb_pkg::ACC_W;
   localparam int CW = pbb_pkg::CORNER_W;
   localparam int F  = pbb_pkg::FRAC_BITS;
   localparam logic [CW-1:0] LAST_CORNER = CW'(pbb_pkg::NUM_CORNERS - 1);

   // ---------------------------------------------------------------- CSRs
   logic [AW-1:0] m01_ff, m23_ff, m1a_ff, m1b_ff, m2a_ff, m2b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         m01_ff <= 64'h0001_0000_0000_0000;
         m23_ff <= '0;
         m1a_ff <= 64'h0000_0000_0001_0000;
         m1b_ff <= '0;
         m2a_ff <= '0;
         m2b_ff <= 64'h0001_0000_0000_0000;
      end else if (csr_valid && csr_ready) begin
         unique case (pbb_pkg::csr_idx_type'(csr_index))
            pbb_pkg::CSR_M00_M01: m01_ff <= csr_wdata;
            pbb_pkg::CSR_M02_M03: m23_ff <= csr_wdata;
            pbb_pkg::CSR_M10_M11: m1a_ff <= csr_wdata;
            pbb_pkg::CSR_M12_M13: m1b_ff <= csr_wdata;
            pbb_pkg::CSR_M20_M21: m2a_ff <= csr_wdata;
            pbb_pkg::CSR_M22_M23: m2b_ff <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Matrix entries, row-major.
   logic signed [WW-1:0] mat [3][4];
   always_comb begin
      mat[0][0] = $signed(m01_ff[AW-1:WW]); mat[0][1] = $signed(m01_ff[WW-1:0]);
      mat[0][2] = $signed(m23_ff[AW-1:WW]); mat[0][3] = $signed(m23_ff[WW-1:0]);
      mat[1][0] = $signed(m1a_ff[AW-1:WW]); mat[1][1] = $signed(m1a_ff[WW-1:0]);
      mat[1][2] = $signed(m1b_ff[AW-1:WW]); mat[1][3] = $signed(m1b_ff[WW-1:0]);
      mat[2][0] = $signed(m2a_ff[AW-1:WW]); mat[2][1] = $signed(m2a_ff[WW-1:0]);
      mat[2][2] = $signed(m2b_ff[AW-1:WW]); mat[2][3] = $signed(m2b_ff[WW-1:0]);
   end

   // ------------------------------------------------- corner sequencer
   logic                 active_ff, active_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [WW-1:0] bx_ff [2];
   logic signed [WW-1:0] by_ff [2];
   logic signed [WW-1:0] bz_ff [2];
   logic                 take;

   // Busy only until the last corner issues, so the next box overlaps.
   assign busy = active_ff && (cnt_ff != LAST_CORNER);
   assign take = start && !busy;

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (take) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (active_ff) begin
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST_CORNER) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold the box for its eight corners.
   always_ff @(posedge clock) begin
      if (take) begin
         bx_ff[0] <= req_box_min_x; bx_ff[1] <= req_box_max_x;
         by_ff[0] <= req_box_min_y; by_ff[1] <= req_box_max_y;
         bz_ff[0] <= req_box_min_z; bz_ff[1] <= req_box_max_z;
      end
   end

   // ---------------------------------------------- stage 1: corner select
   logic signed [WW-1:0] cx_ff, cy_ff, cz_ff;
   pbb_pkg::tag_type     t1_ff, t1_in;

   always_comb begin
      t1_in.valid = active_ff;
      t1_in.first = (cnt_ff == '0);
      t1_in.last  = (cnt_ff == LAST_CORNER);
      t1_in.degen = 1'b0;
   end

   always_ff @(posedge clock) begin
      cx_ff <= bx_ff[cnt_ff[0]];
      cy_ff <= by_ff[cnt_ff[1]];
      cz_ff <= bz_ff[cnt_ff[2]];
      if (reset) begin
         t1_ff <= '0;
      end else begin
         t1_ff <= t1_in;
      end
   end

   // ---------------------------------------------- stage 2: products
   logic signed [AW-1:0] prod_ff [3][4];
   pbb_pkg::tag_type     t2_ff;

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         prod_ff[r][0] <= AW'(mat[r][0]) * AW'(cx_ff);
         prod_ff[r][1] <= AW'(mat[r][1]) * AW'(cy_ff);
         prod_ff[r][2] <= AW'(mat[r][2]) * AW'(cz_ff);
         prod_ff[r][3] <= AW'(mat[r][3]) <<< F;
      end
      if (reset) begin
         t2_ff <= '0;
      end else begin
         t2_ff <= t1_ff;
      end
   end

   // ---------------------------------------------- stage 3: row sums
   logic [AW-1:0]    sum_in [3];
   logic [AW-1:0]    sum_ff [3];
   pbb_pkg::tag_type t3_ff, t3_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2] + prod_ff[r][3];
      end
      t3_in       = t2_ff;
      t3_in.degen = (sum_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         sum_ff[r] <= sum_in[r];
      end
      if (reset) begin
         t3_ff <= '0;
      end else begin
         t3_ff <= t3_in;
      end
   end

   // ---------------------------------------------- divide u and v by w
   logic signed [WW-1:0] pu, pv;
   logic [1:0]           dsat;
   pbb_pkg::tag_type     td;

   pbb_div u_div (
      .clock (clock),
      .reset (reset),
      .num_u (sum_ff[0]),
      .num_v (sum_ff[1]),
      .den   (sum_ff[2]),
      .tag_i (t3_ff),
      .quo_u (pu),
      .quo_v (pv),
      .sat_o (dsat),
      .tag_o (td)
   );

   // ---------------------------------------------- bounds accumulation
   logic                 any_ff, any_in, any_base;
   logic                 dg_ff, dg_in, st_ff, st_in;
   logic signed [WW-1:0] umin_ff, umax_ff, vmin_ff, vmax_ff;
   logic signed [WW-1:0] umin_in, umax_in, vmin_in, vmax_in;

   always_comb begin
      any_base = td.first ? 1'b0 : any_ff;
      dg_in    = (td.first ? 1'b0 : dg_ff) | td.degen;
      st_in    = td.first ? 1'b0 : st_ff;
      umin_in  = umin_ff;
      umax_in  = umax_ff;
      vmin_in  = vmin_ff;
      vmax_in  = vmax_ff;
      any_in   = any_base;
      if (!td.degen) begin
         st_in  = st_in | dsat[0] | dsat[1];
         any_in = 1'b1;
         if (!any_base) begin
            umin_in = pu; umax_in = pu;
            vmin_in = pv; vmax_in = pv;
         end else begin
            if (pu < umin_ff) umin_in = pu;
            if (pu > umax_ff) umax_in = pu;
            if (pv < vmin_ff) vmin_in = pv;
            if (pv > vmax_ff) vmax_in = pv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (td.valid) begin
         umin_ff <= umin_in;
         umax_ff <= umax_in;
         vmin_ff <= vmin_in;
         vmax_ff <= vmax_in;
      end
      if (reset) begin
         any_ff <= 1'b0;
         dg_ff  <= 1'b0;
         st_ff  <= 1'b0;
      end else if (td.valid) begin
         any_ff <= any_in;
         dg_ff  <= dg_in;
         st_ff  <= st_in;
      end
   end

   // ---------------------------------------------- result register
   logic rv_ff;
   logic signed [WW-1:0] rumin_ff, rumax_ff, rvmin_ff, rvmax_ff;
   logic rdg_ff, rst_ff;

   always_ff @(posedge clock) begin
      if (td.valid && td.last) begin
         rumin_ff <= any_in ? umin_in : '0;
         rumax_ff <= any_in ? umax_in : '0;
         rvmin_ff <= any_in ? vmin_in : '0;
         rvmax_ff <= any_in ? vmax_in : '0;
         rdg_ff   <= dg_in;
         rst_ff   <= st_in;
      end
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= td.valid && td.last;
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_image_min_u = rumin_ff;
   assign rsp_image_max_u = rumax_ff;
   assign rsp_image_min_v = rvmin_ff;
   assign rsp_image_max_v = rvmax_ff;
   assign rsp_degenerate  = rdg_ff;
   assign rsp_saturated   = rst_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for projected_box_bounds: random and directed boxes against a predictor.
module tb_top;
   localparam int WORD_W      = pbb_pkg::WORD_W;
   localparam int ACC_W       = pbb_pkg::ACC_W;
   localparam int CSR_IDX_W   = pbb_pkg::CSR_IDX_W;
   localparam int FRAC_BITS   = pbb_pkg::FRAC_BITS;
   localparam int NUM_CORNERS = pbb_pkg::NUM_CORNERS;

   // Register indexes the block has no register for; writes to them must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int NUM_REGS    = 6;
   localparam int DRAIN_WAIT  = 80;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [WORD_W-1:0] min_u, max_u, min_v, max_v;
      logic                     degen, sat;
   } bounds_type;

   typedef struct {
      logic signed [WORD_W-1:0] x0, x1, y0, y1, z0, z1;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [WORD_W-1:0] req_box_min_x = '0, req_box_max_x = '0;
   logic signed [WORD_W-1:0] req_box_min_y = '0, req_box_max_y = '0;
   logic signed [WORD_W-1:0] req_box_min_z = '0, req_box_max_z = '0;
   logic rsp_valid;
   logic signed [WORD_W-1:0] rsp_image_min_u, rsp_image_max_u;
   logic signed [WORD_W-1:0] rsp_image_min_v, rsp_image_max_v;
   logic rsp_degenerate, rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ACC_W-1:0]     csr_wdata = '0;

   // Shadow copy of the camera matrix registers.
   logic [ACC_W-1:0] cam_regs [NUM_REGS];
   bounds_type pending_bounds [$];
   int  errors = 0;
   int  cycles = 0;
   bit  burst_mode = 0;   // when set, idle_gap adds no gaps between boxes

   projected_box_bounds dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_bounds.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic logic signed [WORD_W-1:0] cam_entry(int row, int col);
      logic [ACC_W-1:0] r;
      r = cam_regs[row * 2 + col / 2];
      return (col % 2) ? r[31:0] : r[63:32];
   endfunction

   // One matrix row dotted with (x,y,z,1); sums wrap at 64 bits.
   function automatic logic [ACC_W-1:0] row_dot(int row, logic signed [WORD_W-1:0] x,
                                                logic signed [WORD_W-1:0] y,
                                                logic signed [WORD_W-1:0] z);
      logic [ACC_W-1:0] acc;
      longint t;
      acc = longint'(cam_entry(row, 0)) * longint'(x);
      acc += longint'(cam_entry(row, 1)) * longint'(y);
      acc += longint'(cam_entry(row, 2)) * longint'(z);
      t = longint'(cam_entry(row, 3));
      acc += (ACC_W'(t) << FRAC_BITS);
      return acc;
   endfunction

   // Fixed-point quotient, truncated toward zero, clamped to 32 bits.
   function automatic longint fixed_quotient(logic [ACC_W-1:0] num, logic [ACC_W-1:0] den,
                                             inout bit sat);
      bit neg;
      logic [ACC_W-1:0] mn, md, q, r;
      neg = num[63] ^ den[63];
      mn  = num[63] ? -num : num;
      md  = den[63] ? -den : den;
      q   = mn / md;
      r   = mn % md;
      if ((q >> (WORD_W - FRAC_BITS)) != 0) begin
         sat = 1;
         return neg ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
      end
      // restoring steps; the shift wraps at 64 bits
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= md) begin
            r = r - md;
            q[0] = 1'b1;
         end
      end
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1;
            return -longint'(64'h8000_0000);
         end
         return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1;
         return longint'(64'h7FFF_FFFF);
      end
      return longint'(q);
   endfunction

   function automatic bounds_type project_box(box_type b);
      bounds_type res;
      logic signed [WORD_W-1:0] xs[2], ys[2], zs[2];
      logic [ACC_W-1:0] u, v, w;
      longint pu, pv, umin, umax, vmin, vmax;
      bit any, degen, sat;
      xs = '{b.x0, b.x1}; ys = '{b.y0, b.y1}; zs = '{b.z0, b.z1};
      any = 0; degen = 0; sat = 0;
      umin = 0; umax = 0; vmin = 0; vmax = 0;
      for (int c = 0; c < NUM_CORNERS; c++) begin
         u = row_dot(0, xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1]);
         v = row_dot(1, xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1]);
         w = row_dot(2, xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1]);
         if (w == 0) begin
            degen = 1;
            continue;
         end
         pu = fixed_quotient(u, w, sat);
         pv = fixed_quotient(v, w, sat);
         if (!any) begin
            umin = pu; umax = pu; vmin = pv; vmax = pv;
            any = 1;
         end else begin
            if (pu < umin) umin = pu;
            if (pu > umax) umax = pu;
            if (pv < vmin) vmin = pv;
            if (pv > vmax) vmax = pv;
         end
      end
      res.min_u = umin[31:0]; res.max_u = umax[31:0];
      res.min_v = vmin[31:0]; res.max_v = vmax[31:0];
      res.degen = degen; res.sat = sat;
      return res;
   endfunction

   // ---------------- result checker ----------------
   // Sample at the falling edge, where every output has settled.
   always @(negedge clock) begin
      bounds_type exp_b;
      if (!reset && rsp_valid) begin
         if (pending_bounds.size() == 0) begin
            $display("%0t unexpected result: min_u=%h max_u=%h", $time,
                     rsp_image_min_u, rsp_image_max_u);
            errors++;
         end else begin
            exp_b = pending_bounds.pop_front();
            if (rsp_image_min_u !== exp_b.min_u) begin
               $display("%0t min_u expected %h actual %h", $time, exp_b.min_u, rsp_image_min_u);
               errors++;
            end
            if (rsp_image_max_u !== exp_b.max_u) begin
               $display("%0t max_u expected %h actual %h", $time, exp_b.max_u, rsp_image_max_u);
               errors++;
            end
            if (rsp_image_min_v !== exp_b.min_v) begin
               $display("%0t min_v expected %h actual %h", $time, exp_b.min_v, rsp_image_min_v);
               errors++;
            end
            if (rsp_image_max_v !== exp_b.max_v) begin
               $display("%0t max_v expected %h actual %h", $time, exp_b.max_v, rsp_image_max_v);
               errors++;
            end
            if (rsp_degenerate !== exp_b.degen) begin
               $display("%0t degenerate expected %b actual %b", $time, exp_b.degen,
                        rsp_degenerate);
               errors++;
            end
            if (rsp_saturated !== exp_b.sat) begin
               $display("%0t saturated expected %b actual %b", $time, exp_b.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // ---------------- drivers ----------------
   // Mostly short gaps, now and then a long one; none in burst mode.
   function automatic int idle_gap();
      if (burst_mode) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7:       return $urandom_range(1, 3);
         8:             return $urandom_range(4, 12);
         default:       return $urandom_range(20, 60);
      endcase
   endfunction

   // Present one box and hold it until the block takes the transfer.
   task automatic send_box(box_type b);
      bit taken;
      int gap;
      start         <= 1'b1;
      req_box_min_x <= b.x0; req_box_max_x <= b.x1;
      req_box_min_y <= b.y0; req_box_max_y <= b.y1;
      req_box_min_z <= b.z0; req_box_max_z <= b.z1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      pending_bounds.push_back(project_box(b));
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let every outstanding result arrive, then give the pipeline time to empty.
   task automatic drain();
      start <= 1'b0;
      while (pending_bounds.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Hold valid across back-to-back writes; drop it with csr_idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ACC_W-1:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      if (idx < NUM_REGS) cam_regs[idx] = data;
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
   endtask

   task automatic load_matrix(logic [ACC_W-1:0] m [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) write_csr(CSR_IDX_W'(i), m[i]);
      csr_idle();
   endtask

   // ---------------- stimulus helpers ----------------
   function automatic logic signed [WORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2:       return 32'($urandom_range(0, 1 << 25)) - (1 << 24);
         default: return 32'($urandom_range(0, 1 << 21)) - (1 << 20);
      endcase
   endfunction

   // Well-formed boxes most of the time, swapped bounds and raw noise otherwise.
   function automatic box_type rand_box();
      box_type b;
      logic signed [WORD_W-1:0] a, c;
      logic signed [WORD_W-1:0] v[6];
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         a = rand_coord();
         c = rand_coord();
         if (kind < 8 && a > c) begin
            v[2*i] = c; v[2*i+1] = a;
         end else begin
            v[2*i] = a; v[2*i+1] = c;
         end
      end
      b = '{v[0], v[1], v[2], v[3], v[4], v[5]};
      return b;
   endfunction

   function automatic logic [WORD_W-1:0] rand_entry();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return $urandom();
         default: return 32'($urandom_range(0, 1 << 19)) - (1 << 18);   // about +-4.0
      endcase
   endfunction

   task automatic load_random_matrix();
      logic [ACC_W-1:0] m [NUM_REGS];
      for (int i = 0; i < NUM_REGS; i++) m[i] = {rand_entry(), rand_entry()};
      // keep w mostly away from zero so most corners divide
      if ($urandom_range(0, 3) != 0) m[5][31:0] = 32'($urandom_range(1 << 16, 8 << 16));
      load_matrix(m);
   endtask

   function automatic box_type make_box(int x0, int x1, int y0, int y1, int z0, int z1);
      box_type b;
      b = '{x0, x1, y0, y1, z0, z1};
      return b;
   endfunction

   // ---------------- tests ----------------
   // Reset matrix: extremes, a corner on w zero, saturation, swapped bounds.
   task automatic test_reset_matrix();
      send_box(make_box(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000,
                        32'h0001_0000, 32'h0002_0000));
      send_box(make_box(-32'sh10000, 32'h10000, -32'sh10000, 32'h10000, 0, 32'h10000));
      send_box(make_box(0, 0, 0, 0, 0, 0));                         // every corner degenerate
      send_box(make_box(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh7FFF_FFFF));
      send_box(make_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                        1, 1));                                     // huge over tiny w
      send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        -1, -1));
      send_box(make_box(32'h0005_0000, 32'h0001_0000, 32'h0004_0000, -32'sh20000,
                        32'h0003_0000, 32'h0001_0000));             // min above max
      send_box(make_box(-1, -1, -1, -1, 32'sh8000_0000, 32'sh8000_0000));
      send_box(make_box(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                        32'hF0F0_F0F0, 32'h3333_3333));
      drain();
   endtask

   // Writes to indexes with no register must leave the matrix alone.
   task automatic test_spare_indexes();
      write_csr(CSR_SPARE_6, {$urandom(), $urandom()});
      write_csr(CSR_SPARE_7, {$urandom(), $urandom()});
      csr_idle();
      send_box(make_box(32'h0001_0000, 32'h0004_0000, -32'sh30000, 32'h0002_0000,
                        32'h0002_0000, 32'h0006_0000));
      send_box(make_box(-32'sh7000, 32'h9000, 32'h1234, 32'h8765, 32'h100, 32'h2000));
      drain();
   endtask

   // Extreme matrices: all maximum, all minimum, all zero, all minus one.
   task automatic test_extreme_matrices();
      logic [ACC_W-1:0] m [NUM_REGS];
      logic [WORD_W-1:0] fills[4];
      fills = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      foreach (fills[f]) begin
         for (int i = 0; i < NUM_REGS; i++) m[i] = {fills[f], fills[f]};
         load_matrix(m);
         send_box(make_box(1, 2, 3, 4, 5, 6));
         send_box(make_box(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                           32'sh8000_0000, 32'sh7FFF_FFFF));
         send_box(rand_box());
         drain();
      end
   endtask

   // Many random matrices, each with a run of random boxes.
   task automatic test_random_boxes(int total);
      int sent;
      int run;
      sent = 0;
      while (sent < total) begin
         load_random_matrix();
         burst_mode = ($urandom_range(0, 3) == 0);
         run = $urandom_range(20, 80);
         for (int i = 0; i < run && sent < total; i++) begin
            send_box(rand_box());
            sent++;
            // hold off now and then until every result is back
            if ($urandom_range(0, 199) == 0) begin
               start <= 1'b0;
               while (pending_bounds.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      burst_mode = 0;
   endtask

   initial begin
      cam_regs = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000,
                   64'h0, 64'h0, 64'h0001_0000_0000_0000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_matrix();
      test_spare_indexes();
      test_extreme_matrices();
      // one explicit pause with everything drained before going on
      send_box(rand_box());
      start <= 1'b0;
      while (pending_bounds.size() != 0) @(posedge clock);
      test_random_boxes(1720);

      drain();
      if (errors == 0 && pending_bounds.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// File: filelist.f
rtl/pbb_pkg.sv
rtl/pbb_div.sv
rtl/projected_box_bounds.sv
tb/tb_top.sv
